>>> rtl/avsc_pkg.sv
// ----------------------------------------------------------------------------
// avsc_pkg
// Shared widths, limits, register indexes and pipeline types of the affine
// visual servo command unit.
// ----------------------------------------------------------------------------
package avsc_pkg;

  localparam int LIN_W      = 18;
  localparam int SHIFT_W    = 17;
  localparam int YAW_W      = 15;
  localparam int FWD_W      = 16;
  localparam int GAIN_W     = 24;
  localparam int SIZE_W     = 12;
  localparam int QCX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int U_W        = 32;
  localparam int SQRT_RW    = 20;
  localparam int DIV_NW     = 47;
  localparam int DIV_DW     = 24;
  localparam int DIV_QW     = 15;

  localparam int YAW_LIMIT  = 8192;
  localparam int FWD_LIMIT  = 16384;

  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_SP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TMPL_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TMPL_H    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QCX       = 3'd5;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw_cmd;
    logic                    yaw_clamped;
    logic                    area_sat;
    logic                    fwd_neg;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    logic fwd_sat;
  } div_side_t;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw_cmd;
    logic signed [FWD_W-1:0] forward_cmd;
    logic                    yaw_clamped;
    logic                    forward_clamped;
  } out_item_t;

endpackage

>>> rtl/avsc_if.sv
// ----------------------------------------------------------------------------
// avsc_if
// Valid/ready channels: affine transform items in, command items out.
// ----------------------------------------------------------------------------
interface avsc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [avsc_pkg::LIN_W-1:0]    lin_xx;
  logic signed [avsc_pkg::LIN_W-1:0]    lin_xy;
  logic signed [avsc_pkg::SHIFT_W-1:0]  shift_x;
  logic signed [avsc_pkg::LIN_W-1:0]    lin_yx;
  logic signed [avsc_pkg::LIN_W-1:0]    lin_yy;

  modport source (output valid, lin_xx, lin_xy, shift_x, lin_yx, lin_yy, input ready);
  modport sink   (input valid, lin_xx, lin_xy, shift_x, lin_yx, lin_yy, output ready);
endinterface

interface avsc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [avsc_pkg::YAW_W-1:0]   yaw_cmd;
  logic signed [avsc_pkg::FWD_W-1:0]   forward_cmd;
  logic                                yaw_clamped;
  logic                                forward_clamped;

  modport source (output valid, yaw_cmd, forward_cmd, yaw_clamped, forward_clamped,
                  input ready);
  modport sink   (input valid, yaw_cmd, forward_cmd, yaw_clamped, forward_clamped,
                  output ready);
endinterface

>>> rtl/avsc_sqrt.sv
// ----------------------------------------------------------------------------
// avsc_sqrt
// Two-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module avsc_sqrt #(
  parameter int RW = avsc_pkg::SQRT_RW,
  parameter int SW = avsc_pkg::U_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [2*RW-1:0] x0_i,
  input  logic [2*RW-1:0] x1_i,
  input  logic [SW-1:0]   side_i,
  output logic            out_v,
  output logic [RW-1:0]   r0_o,
  output logic [RW-1:0]   r1_o,
  output logic [SW-1:0]   side_o
);
  localparam int XW = 2 * RW;

  logic [RW-1:0] v_r;
  logic [XW-1:0] x0_r [RW];
  logic [XW-1:0] x1_r [RW];
  logic [XW:0]   q0_r [RW];
  logic [XW:0]   q1_r [RW];
  logic [SW-1:0] side_r [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int SH = 2 * (RW - 1 - j);
    logic [XW:0]   b;
    logic          vin;
    logic [XW-1:0] x0in, x1in;
    logic [XW:0]   q0in, q1in, t0, t1;
    logic [SW-1:0] sin;
    logic          ge0, ge1;
    logic [XW-1:0] x0_nxt, x1_nxt;
    logic [XW:0]   q0_nxt, q1_nxt;

    assign b = {{XW{1'b0}}, 1'b1} << SH;

    if (j == 0) begin : g_first
      assign vin  = in_v;
      assign x0in = x0_i;
      assign x1in = x1_i;
      assign q0in = '0;
      assign q1in = '0;
      assign sin  = side_i;
    end else begin : g_next
      assign vin  = v_r[j-1];
      assign x0in = x0_r[j-1];
      assign x1in = x1_r[j-1];
      assign q0in = q0_r[j-1];
      assign q1in = q1_r[j-1];
      assign sin  = side_r[j-1];
    end

    always_comb begin
      t0     = q0in + b;
      t1     = q1in + b;
      ge0    = {1'b0, x0in} >= t0;
      ge1    = {1'b0, x1in} >= t1;
      x0_nxt = ge0 ? x0in - t0[XW-1:0] : x0in;
      x1_nxt = ge1 ? x1in - t1[XW-1:0] : x1in;
      q0_nxt = ge0 ? (q0in >> 1) + b : q0in >> 1;
      q1_nxt = ge1 ? (q1in >> 1) + b : q1in >> 1;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x0_r[j]   <= x0_nxt;
        x1_r[j]   <= x1_nxt;
        q0_r[j]   <= q0_nxt;
        q1_r[j]   <= q1_nxt;
        side_r[j] <= sin;
      end
    end
  end

  assign out_v  = v_r[RW-1];
  assign r0_o   = q0_r[RW-1][RW-1:0];
  assign r1_o   = q1_r[RW-1][RW-1:0];
  assign side_o = side_r[RW-1];

endmodule

>>> rtl/avsc_div.sv
// ----------------------------------------------------------------------------
// avsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module avsc_div #(
  parameter int NW = avsc_pkg::DIV_NW,
  parameter int DW = avsc_pkg::DIV_DW,
  parameter int QW = avsc_pkg::DIV_QW,
  parameter int SW = $bits(avsc_pkg::div_side_t)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          out_v,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic [QW-1:0] v_r;
  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic          vin;
    logic [NW-1:0] remin, ds, rem_nxt;
    logic [QW-1:0] quoin, quo_nxt;
    logic [SW-1:0] sin;
    logic          ge;

    if (j == 0) begin : g_first
      assign vin   = in_v;
      assign remin = num_i;
      assign quoin = '0;
      assign sin   = side_i;
    end else begin : g_next
      assign vin   = v_r[j-1];
      assign remin = rem_r[j-1];
      assign quoin = quo_r[j-1];
      assign sin   = side_r[j-1];
    end

    always_comb begin
      ds      = NW'(den_i) << K;
      ge      = remin >= ds;
      rem_nxt = ge ? remin - ds : remin;
      quo_nxt = {quoin[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        quo_r[j]  <= quo_nxt;
        side_r[j] <= sin;
      end
    end
  end

  assign out_v  = v_r[QW-1];
  assign quo_o  = quo_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

>>> rtl/affine_visual_servo_command_unit.sv
// ----------------------------------------------------------------------------
// affine_visual_servo_command_unit
// Yaw and forward commands from one fitted affine transform per frame.
// ----------------------------------------------------------------------------
// Pipeline: 2 front stages, 20 square-root stages, 6 multiply stages,
// 15 divider stages and 1 output stage, from input accept to result valid.
// Throughput: one item per cycle; a one-entry skid buffer holds a result the
// sink has not taken, and input ready drops only while that buffer is full.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module affine_visual_servo_command_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [avsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [avsc_pkg::CFG_DATA_W-1:0] cfg_data,
  avsc_in_if.sink                         in_ch,
  avsc_out_if.source                      out_ch
);
  import avsc_pkg::*;

  // configuration
  logic [GAIN_W-1:0] yaw_gain_r, area_gain_r, area_sp_r;
  logic [SIZE_W-1:0] tmpl_w_r, tmpl_h_r;
  logic [QCX_W-1:0]  qcx_r;
  logic [GAIN_W-1:0] sp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_gain_r  <= '0;
      area_gain_r <= '0;
      area_sp_r   <= GAIN_W'(1);
      tmpl_w_r    <= SIZE_W'(1);
      tmpl_h_r    <= SIZE_W'(1);
      qcx_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_YAW_GAIN:  yaw_gain_r  <= cfg_data;
        REG_AREA_GAIN: area_gain_r <= cfg_data;
        REG_AREA_SP:   area_sp_r   <= cfg_data;
        REG_TMPL_W:    tmpl_w_r    <= cfg_data[SIZE_W-1:0];
        REG_TMPL_H:    tmpl_h_r    <= cfg_data[SIZE_W-1:0];
        REG_QCX:       qcx_r       <= cfg_data[QCX_W-1:0];
        default: ;
      endcase
    end
  end

  assign sp = (area_sp_r == '0) ? GAIN_W'(1) : area_sp_r;

  logic en;
  logic skid_v_r;
  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // S1: centre products, squares, x offset
  logic               s1_v_r;
  logic signed [30:0] m0_r, m1_r;
  logic signed [17:0] d_r;
  logic [34:0]        sqxx_r, sqyx_r, sqxy_r, sqyy_r;
  logic signed [12:0] tw_s, th_s;
  logic signed [30:0] m0_nxt, m1_nxt;
  logic signed [17:0] d_nxt;
  logic signed [35:0] sqxx, sqyx, sqxy, sqyy;

  always_comb begin
    tw_s   = $signed({1'b0, tmpl_w_r});
    th_s   = $signed({1'b0, tmpl_h_r});
    m0_nxt = in_ch.lin_xx * tw_s;
    m1_nxt = in_ch.lin_xy * th_s;
    d_nxt  = $signed({2'b00, qcx_r}) - $signed({in_ch.shift_x[SHIFT_W-1], in_ch.shift_x});
    sqxx   = in_ch.lin_xx * in_ch.lin_xx;
    sqyx   = in_ch.lin_yx * in_ch.lin_yx;
    sqxy   = in_ch.lin_xy * in_ch.lin_xy;
    sqyy   = in_ch.lin_yy * in_ch.lin_yy;
  end

  // S2: yaw error and column sums of squares
  logic               s2_v_r;
  logic signed [U_W-1:0] u_r;
  logic [35:0]        s0_r, s1_r;
  logic signed [U_W-1:0] u_nxt;

  always_comb begin
    u_nxt = U_W'($signed({d_r, 11'b0})) - U_W'(m0_r) - U_W'(m1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r   <= m0_nxt;
      m1_r   <= m1_nxt;
      d_r    <= d_nxt;
      sqxx_r <= sqxx[34:0];
      sqyx_r <= sqyx[34:0];
      sqxy_r <= sqxy[34:0];
      sqyy_r <= sqyy[34:0];
      u_r    <= u_nxt;
      s0_r   <= {1'b0, sqxx_r} + {1'b0, sqyx_r};
      s1_r   <= {1'b0, sqxy_r} + {1'b0, sqyy_r};
    end
  end

  // column norms
  logic               sq_v;
  logic [SQRT_RW-1:0] n0, n1;
  logic [U_W-1:0]     sq_side;

  avsc_sqrt #(.RW(SQRT_RW), .SW(U_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (s2_v_r),
    .x0_i   ({s0_r, 4'b0}),
    .x1_i   ({s1_r, 4'b0}),
    .side_i (u_r),
    .out_v  (sq_v),
    .r0_o   (n0),
    .r1_o   (n1),
    .side_o (sq_side)
  );

  // M1: norm product, template area, yaw product
  logic        m1_v_r, m2_v_r, m3_v_r, m4_v_r, m5_v_r, m6_v_r;
  logic [39:0] p01_r;
  logic [23:0] wh_r;
  logic [55:0] ym_r;
  logic        uneg_r;
  logic [U_W-1:0] umag;

  assign umag = sq_side[U_W-1] ? U_W'(~sq_side + 1'b1) : sq_side;

  // M2: split area product, yaw rounding
  logic [43:0] ph_r, pl_r;
  tag_t        tag2_r;
  tag_t        tag2_nxt;
  logic [55:0] yround;
  logic [YAW_W-1:0] yabs;
  logic        ysat;

  always_comb begin
    ysat     = ym_r > (56'd1 << 30);
    yround   = ym_r + (56'd1 << 16);
    yabs     = ysat ? YAW_W'(YAW_LIMIT) : {1'b0, yround[30:17]};
    tag2_nxt = '0;
    tag2_nxt.yaw_cmd     = uneg_r ? -$signed(yabs) : $signed(yabs);
    tag2_nxt.yaw_clamped = ysat;
  end

  // M3: full area product, area saturation
  logic [31:0] area_r;
  tag_t        tag3_r;
  tag_t        tag3_nxt;
  logic [63:0] prod;
  logic        asat;

  always_comb begin
    prod = {ph_r, 20'b0} + {20'b0, pl_r};
    asat = |prod[63:56];
    tag3_nxt = tag2_r;
    tag3_nxt.area_sat = asat;
  end

  // M4: area error magnitude and sign
  logic [31:0] emag_r;
  tag_t        tag4_r;
  tag_t        tag4_nxt;
  logic [32:0] err;

  assign err = {1'b0, sp, 8'b0} - {1'b0, area_r};

  always_comb begin
    tag4_nxt = tag3_r;
    tag4_nxt.fwd_neg = err[32];
  end

  // M5: forward product
  logic [55:0] fm_r;
  tag_t        tag5_r;

  // M6: forward saturation, rounded dividend
  logic [DIV_NW-1:0] nq_r;
  div_side_t         ds6_r;
  logic [56:0]       nsum;
  div_side_t         ds6_nxt;

  always_comb begin
    nsum            = {1'b0, fm_r} + {24'b0, sp, 9'b0};
    ds6_nxt.tag     = tag5_r;
    ds6_nxt.fwd_sat = fm_r > {8'b0, sp, 24'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      m5_v_r <= 1'b0;
      m6_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= sq_v;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;
      m6_v_r <= m5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p01_r  <= n0 * n1;
      wh_r   <= tmpl_w_r * tmpl_h_r;
      ym_r   <= yaw_gain_r * umag;
      uneg_r <= sq_side[U_W-1];
      ph_r   <= p01_r[39:20] * wh_r;
      pl_r   <= p01_r[19:0] * wh_r;
      tag2_r <= tag2_nxt;
      area_r <= asat ? '1 : prod[55:24];
      tag3_r <= tag3_nxt;
      emag_r <= err[32] ? 32'(~err + 1'b1) : err[31:0];
      tag4_r <= tag4_nxt;
      fm_r   <= area_gain_r * emag_r;
      tag5_r <= tag4_r;
      nq_r   <= nsum[56:10];
      ds6_r  <= ds6_nxt;
    end
  end

  // relative area error over setpoint
  logic              dv_v;
  logic [DIV_QW-1:0] quo;
  logic [$bits(div_side_t)-1:0] dv_side_raw;
  div_side_t         dv_side;

  avsc_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW), .SW($bits(div_side_t))) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (m6_v_r),
    .num_i  (nq_r),
    .den_i  (sp),
    .side_i (ds6_r),
    .out_v  (dv_v),
    .quo_o  (quo),
    .side_o (dv_side_raw)
  );

  assign dv_side = dv_side_raw;

  // output stage and skid buffer
  logic        p_v_r;
  out_item_t   p_d_r, p_nxt, skid_d_r, o_d;
  logic [FWD_W-1:0] fabs;

  always_comb begin
    fabs                  = dv_side.fwd_sat ? FWD_W'(FWD_LIMIT) : {1'b0, quo};
    p_nxt.yaw_cmd         = dv_side.tag.yaw_cmd;
    p_nxt.yaw_clamped     = dv_side.tag.yaw_clamped;
    p_nxt.forward_cmd     = dv_side.tag.fwd_neg ? -$signed(fabs) : $signed(fabs);
    p_nxt.forward_clamped = dv_side.fwd_sat | dv_side.tag.area_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r    <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        p_v_r <= dv_v;
      end
      if (!skid_v_r) begin
        skid_v_r <= p_v_r && !out_ch.ready;
      end else if (out_ch.ready) begin
        skid_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d_r <= p_nxt;
    end
    if (!skid_v_r) begin
      skid_d_r <= p_d_r;
    end
  end

  assign o_d                    = skid_v_r ? skid_d_r : p_d_r;
  assign out_ch.valid           = skid_v_r | p_v_r;
  assign out_ch.yaw_cmd         = o_d.yaw_cmd;
  assign out_ch.forward_cmd     = o_d.forward_cmd;
  assign out_ch.yaw_clamped     = o_d.yaw_clamped;
  assign out_ch.forward_clamped = o_d.forward_clamped;

`ifndef ASSERT_OFF
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && $stable(skid_d_r))
    else $error("skid entry lost while stalled");

  a_skid_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !in_ch.ready && out_ch.valid)
    else $error("input taken while skid buffer full");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.yaw_cmd) <= YAW_LIMIT &&
                      $signed(out_ch.yaw_cmd) >= -YAW_LIMIT))
    else $error("yaw command out of range");

  a_yaw_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.yaw_clamped |->
      ($signed(out_ch.yaw_cmd) == YAW_LIMIT || $signed(out_ch.yaw_cmd) == -YAW_LIMIT))
    else $error("clamped yaw not at limit");

  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.forward_cmd) <= FWD_LIMIT &&
                      $signed(out_ch.forward_cmd) >= -FWD_LIMIT))
    else $error("forward command out of range");
`endif

endmodule
